// File: design/ekwd_pkg.sv
// shared types and constants of the escalating kill watchdog
// no dependencies; used by ekwd_cfg and escalating_kill_watchdog_core
package ekwd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned SECS_W   = 16;
  localparam int unsigned TARGET_W = 22;
  localparam int unsigned SIG_W    = 7;
  localparam int unsigned TPS_W    = 10;
  localparam int unsigned KD_W     = 8;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned KPROD_W  = KD_W + TPS_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [TPS_W-1:0]  RST_TPS       = TPS_W'(10);
  localparam logic [KD_W-1:0]   RST_KD        = KD_W'(5);
  localparam logic [BASE_W-1:0] RST_BASE      = BASE_W'(10);
  localparam logic [CODE_W-1:0] RST_TIMEOUT   = CODE_W'(124);
  localparam logic [CODE_W-1:0] RST_SIG_BASE  = CODE_W'(128);

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_ABORT  = 2'd1,
    REQ_RELOAD = 2'd2,
    REQ_ARM    = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS          = 3'd0,
    CFG_KILL_DELAY   = 3'd1,
    CFG_BASE_TIMEOUT = 3'd2,
    CFG_TIMEOUT_CODE = 3'd3,
    CFG_SIG_BASE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TPS_W-1:0]  ticks_per_second;
    logic [CODE_W-1:0] timeout_exit_code;
    logic [CODE_W-1:0] signal_code_base;
  } cfg_t;

  typedef struct packed {
    req_type_e           req_type;
    logic [SECS_W-1:0]   timeout_seconds;
    logic [TARGET_W-1:0] target_id;
    logic [SIG_W-1:0]    signal_number;
    logic                target_alive;
  } in_item_t;

  typedef struct packed {
    logic                send_term;
    logic                send_kill;
    logic [TARGET_W-1:0] current_target;
    logic                finished;
    logic [CODE_W-1:0]   exit_code;
  } out_item_t;

endpackage

// File: design/ekwd_cfg.sv
// configuration registers, scaled products and countdown marks
// depends on ekwd_pkg
module ekwd_cfg #(
  parameter int unsigned CountBits = ekwd_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ekwd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ekwd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output ekwd_pkg::cfg_t                     cfg_o,
  output logic signed [CountBits-1:0]        kill_mark_o,
  output logic signed [CountBits-1:0]        fin_mark_o,
  output logic signed [CountBits-1:0]        init_mark_o,
  output logic signed [CountBits-1:0]        base_ticks_o,
  output logic                               cfg_hit_o,
  output logic signed [CountBits-1:0]        next_fin_mark_o,
  output logic signed [CountBits-1:0]        next_init_mark_o
);

  localparam int unsigned ProdW = ekwd_pkg::BASE_W + ekwd_pkg::TPS_W;
  localparam int unsigned ExtW  = ((CountBits > ProdW) ? CountBits : ProdW) + 1;
  localparam logic [ExtW-1:0] SatMax = ExtW'({1'b0, {(CountBits-1){1'b1}}});
  localparam logic [ExtW-1:0] MinMag = ExtW'(1) << (CountBits - 1);
  localparam logic signed [CountBits-1:0] MinVal = {1'b1, {(CountBits-1){1'b0}}};
  localparam logic [ekwd_pkg::KPROD_W-1:0] KProdRst =
    ekwd_pkg::KPROD_W'(ekwd_pkg::RST_KD * ekwd_pkg::RST_TPS);
  localparam logic signed [CountBits-1:0] BaseRst =
    CountBits'(int'(ekwd_pkg::RST_BASE) * int'(ekwd_pkg::RST_TPS));

  logic [ekwd_pkg::TPS_W-1:0]   tps_q, tps_d;
  logic [ekwd_pkg::KD_W-1:0]    kd_q, kd_d;
  logic [ekwd_pkg::BASE_W-1:0]  base_q, base_d;
  logic [ekwd_pkg::CODE_W-1:0]  tcode_q, tcode_d;
  logic [ekwd_pkg::CODE_W-1:0]  sbase_q, sbase_d;
  logic [ekwd_pkg::KPROD_W-1:0] kprod_q, kprod_d;
  logic signed [CountBits-1:0]  base_ticks_q, base_ticks_d;
  logic [ProdW-1:0]             base_prod;
  logic [ExtW-1:0]              base_ext;
  logic                         hit;

  function automatic logic signed [CountBits-1:0] neg_mark(
    input logic [ekwd_pkg::KPROD_W-1:0] prod,
    input logic [1:0]                   off
  );
    logic [ExtW-1:0] mag;
    logic [ExtW-1:0] neg;
    mag = ExtW'(prod) + ExtW'(off);
    neg = ExtW'(0) - mag;
    if (mag > MinMag) begin
      return MinVal;
    end
    return neg[CountBits-1:0];
  endfunction

  always_comb begin
    tps_d   = tps_q;
    kd_d    = kd_q;
    base_d  = base_q;
    tcode_d = tcode_q;
    sbase_d = sbase_q;
    hit     = 1'b0;
    if (cfg_we_i) begin
      unique case (ekwd_pkg::cfg_idx_e'(cfg_idx_i))
        ekwd_pkg::CFG_TPS: begin
          tps_d = cfg_data_i[ekwd_pkg::TPS_W-1:0];
          hit   = 1'b1;
        end
        ekwd_pkg::CFG_KILL_DELAY: begin
          kd_d = cfg_data_i[ekwd_pkg::KD_W-1:0];
          hit  = 1'b1;
        end
        ekwd_pkg::CFG_BASE_TIMEOUT: begin
          base_d = cfg_data_i[ekwd_pkg::BASE_W-1:0];
          hit    = 1'b1;
        end
        ekwd_pkg::CFG_TIMEOUT_CODE: begin
          tcode_d = cfg_data_i[ekwd_pkg::CODE_W-1:0];
          hit     = 1'b1;
        end
        ekwd_pkg::CFG_SIG_BASE: begin
          sbase_d = cfg_data_i[ekwd_pkg::CODE_W-1:0];
          hit     = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  assign kprod_d   = kd_d * tps_d;
  assign base_prod = base_d * tps_d;
  assign base_ext  = ExtW'(base_prod);
  assign base_ticks_d = (base_ext > SatMax) ? SatMax[CountBits-1:0] : base_ext[CountBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        <= ekwd_pkg::RST_TPS;
      kd_q         <= ekwd_pkg::RST_KD;
      base_q       <= ekwd_pkg::RST_BASE;
      tcode_q      <= ekwd_pkg::RST_TIMEOUT;
      sbase_q      <= ekwd_pkg::RST_SIG_BASE;
      kprod_q      <= KProdRst;
      base_ticks_q <= BaseRst;
    end else if (hit) begin
      tps_q        <= tps_d;
      kd_q         <= kd_d;
      base_q       <= base_d;
      tcode_q      <= tcode_d;
      sbase_q      <= sbase_d;
      kprod_q      <= kprod_d;
      base_ticks_q <= base_ticks_d;
    end
  end

  assign cfg_o.ticks_per_second  = tps_q;
  assign cfg_o.timeout_exit_code = tcode_q;
  assign cfg_o.signal_code_base  = sbase_q;

  assign kill_mark_o      = neg_mark(kprod_q, 2'd0);
  assign fin_mark_o       = neg_mark(kprod_q, 2'd1);
  assign init_mark_o      = neg_mark(kprod_q, 2'd2);
  assign base_ticks_o     = base_ticks_q;
  assign cfg_hit_o        = hit;
  assign next_fin_mark_o  = neg_mark(kprod_d, 2'd1);
  assign next_init_mark_o = neg_mark(kprod_d, 2'd2);

endmodule

// File: design/escalating_kill_watchdog_core.sv
// two-stage watchdog top level: input register, one step of logic, result register
// depends on ekwd_pkg and ekwd_cfg
//
// channel   direction  transaction
// s_axis    in         tuser: req_type; tdata: request fields
// m_axis    out        tdata: result fields; tlast: finished
// cfg       in         write enable, register index, data; no read-back
//
// one item per cycle sustained while m_axis_tready is high; an item passes the input register, then the result register
// the step is one scaling multiply and compares of the countdown against the marks
// reset puts the countdown on the initial mark with reset configuration
// a stalled result register holds the input register, which then stops s_axis
module escalating_kill_watchdog_core #(
  parameter int unsigned CountBits = ekwd_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // timeout_seconds, target_id, signal_number, target_alive, zero fill
  input  logic [ekwd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type
  input  logic [ekwd_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // send_term, send_kill, current_target, exit_code
  output logic [ekwd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [ekwd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ekwd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned ProdW = ekwd_pkg::SECS_W + ekwd_pkg::TPS_W;
  localparam int unsigned ExtW  = ((CountBits > ProdW) ? CountBits : ProdW) + 1;
  localparam logic [ExtW-1:0] SatMax = ExtW'({1'b0, {(CountBits-1){1'b1}}});
  localparam logic signed [CountBits-1:0] Zero = '0;
  localparam logic signed [CountBits-1:0] CdRst =
    CountBits'(-(int'(ekwd_pkg::RST_KD) * int'(ekwd_pkg::RST_TPS) + 2));

  ekwd_pkg::cfg_t              cfg;
  logic signed [CountBits-1:0] kill_m, fin_m, init_m, base_m, next_fin_m, next_init_m;
  logic                        cfg_hit;

  ekwd_cfg #(
    .CountBits(CountBits)
  ) u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cfg_o            (cfg),
    .kill_mark_o      (kill_m),
    .fin_mark_o       (fin_m),
    .init_mark_o      (init_m),
    .base_ticks_o     (base_m),
    .cfg_hit_o        (cfg_hit),
    .next_fin_mark_o  (next_fin_m),
    .next_init_mark_o (next_init_m)
  );

  logic                 in_valid_q;
  ekwd_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  ekwd_pkg::out_item_t  res_q, res_d;
  logic                 s_fire, advance;

  logic signed [CountBits-1:0]         cd_q, cd_d, cd_dec;
  logic                                tv_q, tv_d;
  logic [ekwd_pkg::TARGET_W-1:0]       tgt_q, tgt_d;
  logic                                cl_q, cl_d;
  logic [ekwd_pkg::CODE_W-1:0]         code_q, code_d;
  logic [ProdW-1:0]                    reload_prod;
  logic [ExtW-1:0]                     reload_ext;
  logic signed [CountBits-1:0]         reload_ticks;
  logic                                closed;
  logic                                chk, gone, term, kill, fin;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.req_type        <= ekwd_pkg::req_type_e'(s_axis_tuser);
      in_q.timeout_seconds <= s_axis_tdata[15:0];
      in_q.target_id       <= s_axis_tdata[37:16];
      in_q.signal_number   <= s_axis_tdata[44:38];
      in_q.target_alive    <= s_axis_tdata[45];
    end
  end

  assign reload_prod  = in_q.timeout_seconds * cfg.ticks_per_second;
  assign reload_ext   = ExtW'(reload_prod);
  assign reload_ticks = (reload_ext > SatMax) ? SatMax[CountBits-1:0]
                                              : reload_ext[CountBits-1:0];
  assign cd_dec       = cd_q - CountBits'(1);
  assign closed       = (cd_q != init_m) && (cd_q <= Zero);

  always_comb begin
    cd_d   = cd_q;
    tv_d   = tv_q;
    tgt_d  = tgt_q;
    cl_d   = cl_q;
    code_d = code_q;
    chk    = 1'b0;
    gone   = 1'b0;
    term   = 1'b0;
    kill   = 1'b0;
    fin    = 1'b0;
    unique case (in_q.req_type)
      ekwd_pkg::REQ_TICK: begin
        if (cd_q > fin_m) begin
          cd_d = cd_dec;
          chk  = (cd_dec >= kill_m) && (cd_dec <= Zero);
        end
      end
      ekwd_pkg::REQ_ABORT: begin
        if ((in_q.signal_number != '0) && (cd_q > Zero)) begin
          if (!cl_q) begin
            code_d = cfg.signal_code_base + ekwd_pkg::CODE_W'(in_q.signal_number);
            cl_d   = 1'b1;
          end
          cd_d = Zero;
          chk  = 1'b1;
        end
      end
      ekwd_pkg::REQ_RELOAD: begin
        if (!closed) begin
          cd_d = reload_ticks;
        end
      end
      ekwd_pkg::REQ_ARM: begin
        if (!closed) begin
          tgt_d = in_q.target_id;
          tv_d  = 1'b1;
          if (cd_q < base_m) begin
            cd_d = base_m;
          end
        end
      end
    endcase
    if (chk) begin
      gone = !tv_d || !in_q.target_alive;
      if (!gone && (cd_d == Zero)) begin
        if (!cl_d) begin
          code_d = cfg.timeout_exit_code;
          cl_d   = 1'b1;
        end
        term = 1'b1;
      end
      if (!gone && (cd_d == kill_m)) begin
        kill = 1'b1;
        gone = 1'b1;
      end
      if (gone) begin
        cd_d = fin_m;
        tv_d = 1'b0;
        fin  = cl_d;
      end
    end
  end

  always_comb begin
    res_d.send_term      = term;
    res_d.send_kill      = kill;
    res_d.current_target = tgt_d;
    res_d.finished       = fin;
    res_d.exit_code      = fin ? code_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q   <= CdRst;
      tv_q   <= 1'b0;
      tgt_q  <= '0;
      cl_q   <= 1'b0;
      code_q <= '0;
    end else if (advance) begin
      cd_q   <= cd_d;
      tv_q   <= tv_d;
      tgt_q  <= tgt_d;
      cl_q   <= cl_d;
      code_q <= code_d;
    end else if (cfg_hit) begin
      if (cd_q == init_m) begin
        cd_q <= next_init_m;
      end else if (cd_q == fin_m) begin
        cd_q <= next_fin_m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.finished;
  assign m_axis_tdata  = {res_q.exit_code, res_q.current_target,
                          res_q.send_kill, res_q.send_term};

  a_code_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cl_q |=> cl_q)
    else $error("latched exit code was dropped");

  a_fin_drops_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && fin |=> !tv_q && out_valid_q && res_q.finished)
    else $error("target still valid after finish");

  a_term_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && term |=> cl_q && (cd_q == Zero || cd_q == fin_m))
    else $error("terminate without latched code or off terminate point");

endmodule
